// File: design/joystick_frame_deframer_core_defines.svh
// ----------------------------------------------------------------------------
// Joystick frame deframer assertion macros
// Shared concurrent assertion forms, clocked on clk_i, idle during reset.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define JOYSTICK_FRAME_DEFRAMER_CORE_DEFINES_SVH

// same-cycle implication
`define JFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define JFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// File: design/jfd_pkg.sv
// ----------------------------------------------------------------------------
// Joystick frame deframer package
// Frame geometry, register indexes, shared structs and the axis mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package jfd_pkg;

  // frame geometry: header, body, one footer byte
  localparam int HEAD_BYTES = 1;
  localparam int BODY_BYTES = 4;
  localparam int FRAME_LEN  = HEAD_BYTES + BODY_BYTES + 1;

  localparam int BYTE_W = 8;
  localparam int POS_W  = 3;
  localparam int AXIS_W = 16;
  localparam int IDX_W  = 3;

  // axis map: floor(b * 16384 / 100) = (b * ceil(2^25 / 25)) >> 13
  localparam int QOne       = 16384;
  localparam int AxisRecip  = 1342178;
  localparam int AxisShift  = 13;
  localparam int ProdW      = 29;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    CFG_HEADER   = 3'd0,
    CFG_FOOTER   = 3'd1,
    CFG_X_POS    = 3'd2,
    CFG_Y_POS    = 3'd3,
    CFG_OBST_POS = 3'd4,
    CFG_ARM_POS  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [BYTE_W-1:0] header;
    logic [BYTE_W-1:0] footer;
    logic [POS_W-1:0]  x_pos;
    logic [POS_W-1:0]  y_pos;
    logic [POS_W-1:0]  obst_pos;
    logic [POS_W-1:0]  arm_pos;
  } cfg_t;

  // selected frame bytes, frame_ok marks a good footer on this request
  typedef struct packed {
    logic              frame_ok;
    logic [BYTE_W-1:0] x_byte;
    logic [BYTE_W-1:0] y_byte;
    logic [BYTE_W-1:0] obst_byte;
    logic [BYTE_W-1:0] arm_byte;
  } sel_t;

  // tracker status for checking
  typedef struct packed {
    logic             step;
    logic [POS_W-1:0] pos;
  } trk_stat_t;

  // 0..200 -> -1..1 in signed Q2.14
  function automatic logic signed [AXIS_W-1:0] axis_map(input logic [BYTE_W-1:0] b);
    logic [ProdW-1:0]  prod;
    logic [AXIS_W-1:0] scaled;
    prod     = ProdW'(b) * ProdW'(AxisRecip);
    scaled   = prod[ProdW-1:AxisShift];
    axis_map = $signed(scaled - AXIS_W'(QOne));
  endfunction

endpackage

`default_nettype wire

// File: design/jfd_cfg_regs.sv
// ----------------------------------------------------------------------------
// Joystick frame deframer configuration registers
// Write-only register file decoded from the index of the write port.
// ----------------------------------------------------------------------------
`default_nettype none

module jfd_cfg_regs (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [jfd_pkg::IDX_W-1:0] cfg_idx_i,
  input  wire logic [jfd_pkg::BYTE_W-1:0] cfg_data_i,
  output jfd_pkg::cfg_t                  cfg_o
);

  jfd_pkg::cfg_t cfg_q, cfg_d;

  // register decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (jfd_pkg::cfg_idx_e'(cfg_idx_i))
        jfd_pkg::CFG_HEADER:   cfg_d.header   = cfg_data_i;
        jfd_pkg::CFG_FOOTER:   cfg_d.footer   = cfg_data_i;
        jfd_pkg::CFG_X_POS:    cfg_d.x_pos    = cfg_data_i[jfd_pkg::POS_W-1:0];
        jfd_pkg::CFG_Y_POS:    cfg_d.y_pos    = cfg_data_i[jfd_pkg::POS_W-1:0];
        jfd_pkg::CFG_OBST_POS: cfg_d.obst_pos = cfg_data_i[jfd_pkg::POS_W-1:0];
        jfd_pkg::CFG_ARM_POS:  cfg_d.arm_pos  = cfg_data_i[jfd_pkg::POS_W-1:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header   <= '0;
      cfg_q.footer   <= '0;
      cfg_q.x_pos    <= jfd_pkg::POS_W'(1);
      cfg_q.y_pos    <= jfd_pkg::POS_W'(2);
      cfg_q.obst_pos <= jfd_pkg::POS_W'(3);
      cfg_q.arm_pos  <= jfd_pkg::POS_W'(4);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: design/jfd_frame_track.sv
// ----------------------------------------------------------------------------
// Joystick frame deframer frame tracker
// Input register, frame position counter and capture of the frame bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module jfd_frame_track (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire jfd_pkg::cfg_t              cfg_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [jfd_pkg::BYTE_W-1:0] in_byte_i,
  input  wire logic                       adv_i,
  output jfd_pkg::sel_t                   sel_o,
  output jfd_pkg::trk_stat_t              stat_o
);

  localparam logic [jfd_pkg::POS_W-1:0] FooterPos = jfd_pkg::POS_W'(jfd_pkg::FRAME_LEN - 1);
  // header and body bytes; the footer is taken from the input register
  localparam int StoreLen = jfd_pkg::FRAME_LEN - 1;

  logic                                     in_valid_q, in_valid_d;
  logic [jfd_pkg::BYTE_W-1:0]               in_byte_q;
  logic [jfd_pkg::BYTE_W-1:0]               last_q;
  logic [jfd_pkg::POS_W-1:0]                pos_q, pos_d;
  logic [StoreLen-1:0][jfd_pkg::BYTE_W-1:0] store_q;
  logic                                     fire, step, open, at_footer, capture;

  // pick a frame byte: footer slot is the byte on hand, past the frame is zero
  function automatic logic [jfd_pkg::BYTE_W-1:0] pick(
    input logic [jfd_pkg::POS_W-1:0]                idx,
    input logic [StoreLen-1:0][jfd_pkg::BYTE_W-1:0] frame,
    input logic [jfd_pkg::BYTE_W-1:0]               cur
  );
    pick = '0;
    if (idx == FooterPos) pick = cur;
    for (int i = 0; i < StoreLen; i++) begin
      if (idx == jfd_pkg::POS_W'(i)) pick = frame[i];
    end
  endfunction

  // input register handshake
  assign in_ready_o = !in_valid_q || adv_i;
  assign fire       = in_valid_i && in_ready_o;
  assign step       = in_valid_q && adv_i;

  always_comb begin
    in_valid_d = in_valid_q;
    if (fire)       in_valid_d = 1'b1;
    else if (adv_i) in_valid_d = 1'b0;
  end

  // frame position
  assign open      = (pos_q == '0) && (in_byte_q == cfg_i.header) && (last_q == cfg_i.footer);
  assign at_footer = (pos_q == FooterPos);
  assign capture   = (pos_q == '0) ? open : !at_footer;

  always_comb begin
    pos_d = pos_q;
    if (step) begin
      if (pos_q == '0)    pos_d = open ? jfd_pkg::POS_W'(1) : '0;
      else if (at_footer) pos_d = '0;
      else                pos_d = pos_q + jfd_pkg::POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      pos_q      <= '0;
      last_q     <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      pos_q      <= pos_d;
      if (step) last_q <= in_byte_q;
    end
  end

  // frame byte capture at the current position
  always_ff @(posedge clk_i) begin
    if (fire) in_byte_q <= in_byte_i;
    if (step && capture) begin
      for (int i = 0; i < StoreLen; i++) begin
        if (pos_q == jfd_pkg::POS_W'(i)) store_q[i] <= in_byte_q;
      end
    end
  end

  // selected bytes toward the result stage
  always_comb begin
    sel_o.frame_ok  = step && at_footer && (in_byte_q == cfg_i.footer);
    sel_o.x_byte    = pick(cfg_i.x_pos, store_q, in_byte_q);
    sel_o.y_byte    = pick(cfg_i.y_pos, store_q, in_byte_q);
    sel_o.obst_byte = pick(cfg_i.obst_pos, store_q, in_byte_q);
    sel_o.arm_byte  = pick(cfg_i.arm_pos, store_q, in_byte_q);
  end

  assign stat_o.step = step;
  assign stat_o.pos  = pos_q;

endmodule

`default_nettype wire

// File: design/jfd_result_reg.sv
// ----------------------------------------------------------------------------
// Joystick frame deframer result register
// Axis mapping and the output register of the master stream.
// ----------------------------------------------------------------------------
`default_nettype none

module jfd_result_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire jfd_pkg::sel_t sel_i,
  output logic               adv_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [47:0]        out_data_o
);

  logic        out_valid_q, out_valid_d;
  logic [47:0] out_data_q, out_data_d;

  // stage may move when the result register is empty or being drained
  assign adv_o = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv_o) out_valid_d = sel_i.frame_ok;
  end

  // pack: axis_x, axis_y, obstacle_flag, arm_state from bit 0 up
  always_comb begin
    out_data_d[15:0]  = jfd_pkg::axis_map(sel_i.x_byte);
    out_data_d[31:16] = jfd_pkg::axis_map(sel_i.y_byte);
    out_data_d[39:32] = sel_i.obst_byte;
    out_data_d[47:40] = sel_i.arm_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel_i.frame_ok) out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// File: design/joystick_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// Joystick frame deframer core
// Parses received bytes into header/body/footer frames and emits mapped axes.
// ----------------------------------------------------------------------------
//  channel   dir  width  contents
//  s_axis    in   8      rx_byte
//  m_axis    out  48     axis_x, axis_y, obstacle_flag, arm_state
//  cfg       in   8      register write, index 0..5
//
// One byte is taken per cycle unless the result register stalls; a result
// is made from its footer byte (the input register feeds the result register).
// Reset clears the position counter, the previous byte and all valid flags.
// A stalled result register holds the input register; input keeps flowing
// as long as the input register or the result register is empty, or the
// result register is drained in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "joystick_frame_deframer_core_defines.svh"

module joystick_frame_deframer_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // [15:0] axis_x, [31:16] axis_y,
                                           // [39:32] obstacle_flag, [47:40] arm_state
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i
);

  jfd_pkg::cfg_t      cfg;
  jfd_pkg::sel_t      sel;
  jfd_pkg::trk_stat_t stat;
  logic               adv;

  jfd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  jfd_frame_track u_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .adv_i      (adv),
    .sel_o      (sel),
    .stat_o     (stat)
  );

  jfd_result_reg u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sel_i       (sel),
    .adv_o       (adv),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  // position never runs past the footer slot
  `JFD_ASSERT_NOW(a_pos_range, 1'b1, int'(stat.pos) < jfd_pkg::FRAME_LEN, "frame position out of range")
  // a good frame is only reported on the footer byte
  `JFD_ASSERT_NOW(a_ok_at_footer, sel.frame_ok, stat.step && (int'(stat.pos) == jfd_pkg::FRAME_LEN - 1), "frame_ok off the footer slot")
  // a good frame always reaches the result register
  `JFD_ASSERT_NEXT(a_ok_to_out, sel.frame_ok, m_axis_tvalid, "good frame lost")

endmodule

`default_nettype wire
